// ----- src/smf_pkg.sv -----
// Shared constants, types and helpers of the SEI marker finder.
package smf_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 4096;

   localparam int SCAN_GUARD    = 30;
   localparam int MIN_PAYLOAD   = 21;
   localparam int MARKER_OFFSET = 20;
   localparam int UUID_BYTES    = 16;
   localparam int DCNT_W        = 5;

   localparam logic [7:0] SEI_PAYLOAD_TYPE = 8'h05;
   localparam logic [7:0] EP_BYTE          = 8'h03;
   localparam logic [7:0] SIZE_EXT_BYTE    = 8'hFF;
   localparam logic [4:0] H264_SEI_TYPE    = 5'd6;
   localparam logic [5:0] H265_SEI_PREFIX  = 6'd39;
   localparam logic [5:0] H265_SEI_SUFFIX  = 6'd40;

   localparam logic [63:0] UUID_UPPER_RST = 64'hC19E_6C8F_245A_4B7D;
   localparam logic [63:0] UUID_LOWER_RST = 64'h8E3F_2A1B_0C4D_5E6F;

   localparam logic [1:0] CSR_UUID_UPPER = 2'd0;
   localparam logic [1:0] CSR_UUID_LOWER = 2'd1;

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_B0,
      SCAN_B1,
      SCAN_B2,
      SCAN_B3,
      SCAN_NAL,
      SCAN_PT,
      SCAN_SZ,
      SCAN_UE_FIRST,
      SCAN_UE,
      SCAN_DONE
   } scan_state_type;

   function automatic logic [7:0] uuid_byte(input logic [127:0] uuid, input logic [3:0] k);
      return uuid[{~k, 3'b000} +: 8];
   endfunction

endpackage

// ----- src/smf_loader.sv -----
// Front end: accepts frame words, fills the frame memory and queues a frame job.
module smf_loader #(
   parameter int MAX_FRAME_BYTES = smf_pkg::MAX_FRAME_BYTES_DEF,
   parameter int CNT_W           = $clog2(MAX_FRAME_BYTES + 1),
   parameter int ADDR_W          = $clog2(MAX_FRAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // frame_byte
   input  logic              req_tlast,   // last_byte
   input  logic              mem_free,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic              push,
   output logic [CNT_W-1:0]  push_size,
   output logic              push_ovf
);
   import smf_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             acc;
   logic             room;

   assign req_tready = mem_free;
   assign acc        = req_tvalid & mem_free;
   assign room       = count_ff < CNT_W'(MAX_FRAME_BYTES);

   assign wr_en     = acc & room;
   assign wr_addr   = count_ff[ADDR_W-1:0];
   assign wr_data   = req_tdata;
   assign push_size = room ? count_ff + 1'b1 : count_ff;
   assign push_ovf  = ovf_ff | ~room;
   assign push      = acc & req_tlast;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (acc) begin
         if (req_tlast) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = push_size;
            ovf_in   = push_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- src/smf_job_queue.sv -----
// Two-entry queue of frame jobs between loader and scanner.
module smf_job_queue #(
   parameter int W = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty,
   output logic         full
);
   import smf_pkg::*;

   logic [W-1:0] entry_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign empty    = cnt_ff == 2'd0;
   assign full     = cnt_ff == 2'd2;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- src/smf_scanner.sv -----
// Back end: frame memory and the start-code, SEI header and payload scan.
module smf_scanner #(
   parameter int MAX_FRAME_BYTES = smf_pkg::MAX_FRAME_BYTES_DEF,
   parameter int CNT_W           = $clog2(MAX_FRAME_BYTES + 1),
   parameter int ADDR_W          = $clog2(MAX_FRAME_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [127:0]      uuid,
   input  logic              job_valid,
   input  logic [CNT_W-1:0]  job_size,
   input  logic              job_ovf,
   output logic              job_pop,
   output logic              busy,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata    // marker_value, marker_found, frame_overflow
);
   import smf_pkg::*;

   logic [7:0] mem [MAX_FRAME_BYTES];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   scan_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]  sp_ff, sp_in;
   logic [CNT_W-1:0]  hdr_ff, hdr_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [7:0]        b_ff, b_in;
   logic [DCNT_W-1:0] d_ff, d_in;
   logic [1:0]        zr_ff, zr_in;
   logic              match_ff, match_in;
   logic [7:0]        res_value_ff, res_value_in;
   logic              res_ovf_ff, res_ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        out_value_ff, out_value_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              restart_en;
   logic [CNT_W-1:0]  restart_at;
   logic [CNT_W:0]    pos_p1, pos_p2;
   logic              has_next, skip, nal_ok, h264, h265;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy       = (state_ff != SCAN_IDLE) && (state_ff != SCAN_DONE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_ovf_ff, out_value_ff != 8'h00, out_value_ff};

   assign pos_p1   = {1'b0, pos_ff} + 1'b1;
   assign pos_p2   = {1'b0, pos_ff} + 2'd2;
   assign has_next = pos_p1 < {1'b0, size_ff};
   assign skip     = (zr_ff == 2'd2) && (b_ff == EP_BYTE) && has_next && (rd_data_ff <= EP_BYTE);
   assign nal_ok   = ~rd_data_ff[7];
   assign h264     = nal_ok && (rd_data_ff[4:0] == H264_SEI_TYPE);
   assign h265     = nal_ok && ((rd_data_ff[6:1] == H265_SEI_PREFIX) ||
                                (rd_data_ff[6:1] == H265_SEI_SUFFIX));

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      sp_in        = sp_ff;
      hdr_in       = hdr_ff;
      pos_in       = pos_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      zr_in        = zr_ff;
      match_in     = match_ff;
      res_value_in = res_value_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      out_value_in = out_value_ff;
      out_ovf_in   = out_ovf_ff;
      rd_addr      = '0;
      job_pop      = 1'b0;
      restart_en   = 1'b0;
      restart_at   = sp_ff + 1'b1;

      unique case (state_ff)
         SCAN_IDLE: begin
            if (job_valid) begin
               job_pop    = 1'b1;
               size_in    = job_size;
               res_ovf_in = job_ovf;
               if (job_ovf) begin
                  res_value_in = 8'h00;
                  state_in     = SCAN_DONE;
               end else begin
                  restart_en = 1'b1;
                  restart_at = '0;
               end
            end
         end
         SCAN_B0: begin
            if (rd_data_ff != 8'h00) begin
               restart_en = 1'b1;
            end else begin
               rd_addr  = ADDR_W'(sp_ff + 1'b1);
               state_in = SCAN_B1;
            end
         end
         SCAN_B1: begin
            if (rd_data_ff != 8'h00) begin
               restart_en = 1'b1;
            end else begin
               rd_addr  = ADDR_W'(sp_ff + 2'd2);
               state_in = SCAN_B2;
            end
         end
         SCAN_B2: begin
            if (rd_data_ff == 8'h01) begin
               hdr_in   = sp_ff + 2'd3;
               rd_addr  = ADDR_W'(sp_ff + 2'd3);
               state_in = SCAN_NAL;
            end else if (rd_data_ff == 8'h00) begin
               rd_addr  = ADDR_W'(sp_ff + 2'd3);
               state_in = SCAN_B3;
            end else begin
               restart_en = 1'b1;
            end
         end
         SCAN_B3: begin
            if (rd_data_ff == 8'h01) begin
               hdr_in   = sp_ff + 3'd4;
               rd_addr  = ADDR_W'(sp_ff + 3'd4);
               state_in = SCAN_NAL;
            end else begin
               restart_en = 1'b1;
            end
         end
         SCAN_NAL: begin
            if (h264) begin
               pos_in   = hdr_ff + 1'b1;
               rd_addr  = ADDR_W'(hdr_ff + 1'b1);
               state_in = SCAN_PT;
            end else if (h265) begin
               pos_in   = hdr_ff + 2'd2;
               rd_addr  = ADDR_W'(hdr_ff + 2'd2);
               state_in = SCAN_PT;
            end else begin
               restart_en = 1'b1;
               restart_at = hdr_ff + 1'b1;
            end
         end
         SCAN_PT: begin
            if ((rd_data_ff != SEI_PAYLOAD_TYPE) || (pos_p1 >= {1'b0, size_ff})) begin
               restart_en = 1'b1;
            end else begin
               pos_in   = pos_p1[CNT_W-1:0];
               rd_addr  = pos_p1[ADDR_W-1:0];
               state_in = SCAN_SZ;
            end
         end
         SCAN_SZ: begin
            pos_in = pos_p1[CNT_W-1:0];
            if (rd_data_ff == SIZE_EXT_BYTE) begin
               if (pos_p1 >= {1'b0, size_ff}) begin
                  restart_en = 1'b1;
               end else begin
                  rd_addr = pos_p1[ADDR_W-1:0];
               end
            end else if (({1'b0, size_ff} - pos_p1) < (CNT_W + 1)'(MIN_PAYLOAD)) begin
               restart_en = 1'b1;
            end else begin
               rd_addr  = pos_p1[ADDR_W-1:0];
               zr_in    = 2'd0;
               d_in     = '0;
               match_in = 1'b1;
               state_in = SCAN_UE_FIRST;
            end
         end
         SCAN_UE_FIRST: begin
            b_in     = rd_data_ff;
            rd_addr  = pos_p1[ADDR_W-1:0];
            state_in = SCAN_UE;
         end
         SCAN_UE: begin
            if (skip) begin
               zr_in = 2'd0;
            end else begin
               if ((d_ff < DCNT_W'(UUID_BYTES)) && (b_ff != uuid_byte(uuid, d_ff[3:0]))) begin
                  match_in = 1'b0;
               end
               if (b_ff == 8'h00) begin
                  zr_in = (zr_ff == 2'd2) ? zr_ff : zr_ff + 1'b1;
               end else begin
                  zr_in = 2'd0;
               end
               d_in = d_ff + 1'b1;
            end
            if (!skip && (d_ff == DCNT_W'(MARKER_OFFSET))) begin
               if (match_ff && (b_ff != 8'h00)) begin
                  res_value_in = b_ff;
                  state_in     = SCAN_DONE;
               end else begin
                  restart_en = 1'b1;
                  restart_at = hdr_ff + 1'b1;
               end
            end else if (!has_next) begin
               restart_en = 1'b1;
            end else begin
               pos_in  = pos_p1[CNT_W-1:0];
               b_in    = rd_data_ff;
               rd_addr = pos_p2[ADDR_W-1:0];
            end
         end
         SCAN_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_value_in = res_value_ff;
               out_ovf_in   = res_ovf_ff;
               state_in     = SCAN_IDLE;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase

      if (restart_en) begin
         if (({1'b0, restart_at} + (CNT_W + 1)'(SCAN_GUARD)) < {1'b0, size_in}) begin
            sp_in    = restart_at;
            rd_addr  = restart_at[ADDR_W-1:0];
            state_in = SCAN_B0;
         end else begin
            res_value_in = 8'h00;
            state_in     = SCAN_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      sp_ff        <= sp_in;
      hdr_ff       <= hdr_in;
      pos_ff       <= pos_in;
      b_ff         <= b_in;
      d_ff         <= d_in;
      zr_ff        <= zr_in;
      match_ff     <= match_in;
      res_value_ff <= res_value_in;
      res_ovf_ff   <= res_ovf_in;
      out_value_ff <= out_value_in;
      out_ovf_ff   <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/sei_uuid_marker_finder_unit.sv -----
// Top level of the SEI user-data marker finder: config registers, front, queue, back.
//
// Frame bytes load at one word per cycle into the frame memory while it is free. After the last
// byte the scanner walks the stored frame through the memory's single registered
// read port, one byte per cycle: the start-code search, then the header, size and
// payload bytes examined at each SEI candidate, then posting of the result. The
// loader takes the next frame as soon as the scan has finished, while the result
// may still wait in the output register.
module sei_uuid_marker_finder_unit #(
   parameter int MAX_FRAME_BYTES = smf_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // frame_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // marker_value[7:0], marker_found[8], frame_overflow[9]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import smf_pkg::*;

   localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
   localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);

   logic [63:0]       uuid_upper_ff, uuid_upper_in;
   logic [63:0]       uuid_lower_ff, uuid_lower_in;
   logic              mem_free;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              q_push, q_pop, q_empty, q_full, q_ovf, scan_busy;
   logic [CNT_W-1:0]  q_size;
   logic [CNT_W:0]    q_out;
   logic              push_ovf;
   logic [CNT_W-1:0]  push_size;

   assign csr_ready = 1'b1;
   assign mem_free  = q_empty & ~scan_busy;
   assign q_size    = q_out[CNT_W-1:0];
   assign q_ovf     = q_out[CNT_W];

   always_comb begin
      uuid_upper_in = uuid_upper_ff;
      uuid_lower_in = uuid_lower_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_UUID_UPPER: uuid_upper_in = csr_data;
            CSR_UUID_LOWER: uuid_lower_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uuid_upper_ff <= UUID_UPPER_RST;
         uuid_lower_ff <= UUID_LOWER_RST;
      end else begin
         uuid_upper_ff <= uuid_upper_in;
         uuid_lower_ff <= uuid_lower_in;
      end
   end

   smf_loader #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .CNT_W(CNT_W),
      .ADDR_W(ADDR_W)
   ) u_loader (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .mem_free(mem_free),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .push(q_push),
      .push_size(push_size),
      .push_ovf(push_ovf)
   );

   smf_job_queue #(
      .W(CNT_W + 1)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data({push_ovf, push_size}),
      .pop(q_pop),
      .pop_data(q_out),
      .empty(q_empty),
      .full(q_full)
   );

   smf_scanner #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .CNT_W(CNT_W),
      .ADDR_W(ADDR_W)
   ) u_scanner (
      .clock(clock),
      .reset(reset),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .uuid({uuid_upper_ff, uuid_lower_ff}),
      .job_valid(~q_empty),
      .job_size(q_size),
      .job_ovf(q_ovf),
      .job_pop(q_pop),
      .busy(scan_busy),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("frame job pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("loader took a word while the frame memory was being scanned");

   assert property (@(posedge clock) disable iff (reset)
      (wr_en && scan_busy) |-> 1'b0)
      else $error("frame memory written during a scan");

endmodule
